[design/ipwc_pkg.sv]
// Package for the IR pulse width classifier: widths, codes, windows and shared types.
package ipwc_pkg;

  localparam int COUNT_WIDTH  = 16;
  localparam int TIME_WIDTH   = 16;
  localparam int CODE_WIDTH   = 3;
  localparam int TICKS_PER_MS = 2000;

  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [CODE_WIDTH-1:0] EVT_OFF_LONG  = 3'd0;
  localparam logic [CODE_WIDTH-1:0] EVT_ON_MID    = 3'd1;
  localparam logic [CODE_WIDTH-1:0] EVT_OFF_SHORT = 3'd2;
  localparam logic [CODE_WIDTH-1:0] EVT_ON_SHORT  = 3'd3;
  localparam logic [CODE_WIDTH-1:0] EVT_ON_TINY   = 3'd4;
  localparam logic [CODE_WIDTH-1:0] EVT_ON_LONG   = 3'd5;
  localparam logic [CODE_WIDTH-1:0] EVT_TIMEOUT   = 3'd6;

  localparam logic [COUNT_WIDTH-1:0] W1_LO = COUNT_WIDTH'(3 * TICKS_PER_MS);
  localparam logic [COUNT_WIDTH-1:0] W1_HI = COUNT_WIDTH'(14 * TICKS_PER_MS);
  localparam logic [COUNT_WIDTH-1:0] W2_LO = COUNT_WIDTH'(5 * TICKS_PER_MS / 2);
  localparam logic [COUNT_WIDTH-1:0] W2_HI = COUNT_WIDTH'(6 * TICKS_PER_MS);
  localparam logic [COUNT_WIDTH-1:0] W3_LO = COUNT_WIDTH'(2 * TICKS_PER_MS / 5);
  localparam logic [COUNT_WIDTH-1:0] W3_HI = COUNT_WIDTH'(2 * TICKS_PER_MS);
  localparam logic [COUNT_WIDTH-1:0] W4_LO = COUNT_WIDTH'(21 * TICKS_PER_MS / 20);
  localparam logic [COUNT_WIDTH-1:0] W4_HI = COUNT_WIDTH'(2 * TICKS_PER_MS);
  localparam logic [COUNT_WIDTH-1:0] W5_LO = COUNT_WIDTH'(TICKS_PER_MS / 5);
  localparam logic [COUNT_WIDTH-1:0] W5_HI = COUNT_WIDTH'(1 * TICKS_PER_MS);
  localparam logic [COUNT_WIDTH-1:0] W6_LO = COUNT_WIDTH'(12 * TICKS_PER_MS);
  localparam logic [COUNT_WIDTH-1:0] W6_HI = COUNT_WIDTH'(28 * TICKS_PER_MS);

  typedef struct packed {
    logic                  have_first_edge;
    logic                  edge_seen;
    logic [TIME_WIDTH-1:0] last_time;
    logic                  expect_rising;
  } state_t;

  typedef struct packed {
    logic                  valid;
    logic [CODE_WIDTH-1:0] code;
  } result_t;

  function automatic logic in_window(input logic [COUNT_WIDTH-1:0] d,
                                     input logic [COUNT_WIDTH-1:0] lo,
                                     input logic [COUNT_WIDTH-1:0] hi);
    return (d > lo) && (d < hi);
  endfunction

endpackage

[design/ipwc_if.sv]
// Channel interfaces: edge/tick items in, event codes out.
interface ipwc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [ipwc_pkg::TIME_WIDTH-1:0] capture_time;

  modport source (output valid, output func, output capture_time, input ready);
  modport sink (input valid, input func, input capture_time, output ready);
endinterface

interface ipwc_out_if;
  logic                           valid;
  logic                           ready;
  logic [ipwc_pkg::CODE_WIDTH-1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

[design/ir_pulse_width_classifier.sv]
// An item accepted into the input register has its event loaded into the output register when it advances.
// Throughput: one item per cycle; the input register drains whenever the output
// register is free or being taken, or when the item gives no event.
// Reset (rst, synchronous): both registers empty, no first edge stored, no edge seen,
// last time zero, falling edge expected.
// Top level of the IR pulse width classifier: input register, classifier, output register.
module ir_pulse_width_classifier (
  input logic      clk,
  input logic      rst,
  ipwc_in_if.sink  items,
  ipwc_out_if.source events
);

  logic                            s1_valid;
  logic                            s1_func;
  logic [ipwc_pkg::TIME_WIDTH-1:0] s1_time;
  ipwc_pkg::state_t                st;
  ipwc_pkg::state_t                st_next;
  ipwc_pkg::result_t               res;
  logic                            out_valid;
  logic [ipwc_pkg::CODE_WIDTH-1:0] out_code;
  logic                            advance;

  ipwc_core u_core (
    .st           (st),
    .func         (s1_func),
    .capture_time (s1_time),
    .st_next      (st_next),
    .res          (res)
  );

  assign advance           = s1_valid && (!res.valid || !out_valid || events.ready);
  assign items.ready       = !s1_valid || advance;
  assign events.valid      = out_valid;
  assign events.event_code = out_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (items.valid && items.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        st <= st_next;
      end
      if (advance && res.valid) begin
        out_valid <= 1'b1;
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_func <= items.func;
      s1_time <= items.capture_time;
    end
    if (advance && res.valid) begin
      out_code <= res.code;
    end
  end

endmodule

[design/ipwc_core.sv]
// Classification logic: interval, window compares and next state for one item.
module ipwc_core (
  input  ipwc_pkg::state_t                  st,
  input  logic                              func,
  input  logic [ipwc_pkg::TIME_WIDTH-1:0]   capture_time,
  output ipwc_pkg::state_t                  st_next,
  output ipwc_pkg::result_t                 res
);

  logic [ipwc_pkg::COUNT_WIDTH-1:0] delta;

  assign delta = ipwc_pkg::COUNT_WIDTH'(capture_time) - ipwc_pkg::COUNT_WIDTH'(st.last_time);

  always_comb begin
    st_next   = st;
    res.valid = 1'b0;
    res.code  = ipwc_pkg::EVT_TIMEOUT;
    if (func == ipwc_pkg::FUNC_TICK) begin
      if (!st.edge_seen) begin
        st_next.expect_rising   = 1'b0;
        st_next.have_first_edge = 1'b0;
        res.valid               = 1'b1;
        res.code                = ipwc_pkg::EVT_TIMEOUT;
      end
      st_next.edge_seen = 1'b0;
    end else begin
      st_next.edge_seen = 1'b1;
      st_next.last_time = capture_time;
      if (!st.have_first_edge) begin
        st_next.have_first_edge = 1'b1;
        st_next.expect_rising   = !st.expect_rising;
      end else if (st.expect_rising) begin
        st_next.expect_rising = 1'b0;
        if (ipwc_pkg::in_window(delta, ipwc_pkg::W1_LO, ipwc_pkg::W1_HI)) begin
          res.valid = 1'b1;
          res.code  = ipwc_pkg::EVT_OFF_LONG;
        end else if (ipwc_pkg::in_window(delta, ipwc_pkg::W3_LO, ipwc_pkg::W3_HI)) begin
          res.valid = 1'b1;
          res.code  = ipwc_pkg::EVT_OFF_SHORT;
        end
      end else begin
        st_next.expect_rising = 1'b1;
        if (ipwc_pkg::in_window(delta, ipwc_pkg::W2_LO, ipwc_pkg::W2_HI)) begin
          res.valid = 1'b1;
          res.code  = ipwc_pkg::EVT_ON_MID;
        end else if (ipwc_pkg::in_window(delta, ipwc_pkg::W4_LO, ipwc_pkg::W4_HI)) begin
          res.valid = 1'b1;
          res.code  = ipwc_pkg::EVT_ON_SHORT;
        end else if (ipwc_pkg::in_window(delta, ipwc_pkg::W5_LO, ipwc_pkg::W5_HI)) begin
          res.valid = 1'b1;
          res.code  = ipwc_pkg::EVT_ON_TINY;
        end else if (ipwc_pkg::in_window(delta, ipwc_pkg::W6_LO, ipwc_pkg::W6_HI)) begin
          res.valid = 1'b1;
          res.code  = ipwc_pkg::EVT_ON_LONG;
        end
      end
    end
  end

endmodule

[test/ipwc_event_check.sv]
// Checker for the IR pulse width classifier: predicts event codes and compares each output transfer.
`timescale 1ns / 1ps

module ipwc_event_check
  import ipwc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  ipwc_in_if                    items,
  ipwc_out_if                   events,
  output int                    fail_count,
  output int                    outstanding,
  output int                    events_checked,
  output logic [EVT_TIMEOUT:0]  kinds_seen
);

  logic                   armed;
  logic                   active;
  logic [TIME_WIDTH-1:0]  prev_stamp;
  logic                   want_rise;
  logic [CODE_WIDTH-1:0]  expected_codes[$];

  function automatic logic predict_event_code(input logic kind,
                                              input logic [TIME_WIDTH-1:0] stamp,
                                              output logic [CODE_WIDTH-1:0] code);
    logic [COUNT_WIDTH-1:0] span;
    logic                   hit;
    hit  = 1'b0;
    code = '0;
    if (kind == FUNC_TICK) begin
      if (!active) begin
        want_rise = 1'b0;
        armed     = 1'b0;
        code      = EVT_TIMEOUT;
        hit       = 1'b1;
      end
      active = 1'b0;
    end else begin
      active = 1'b1;
      if (!armed) begin
        armed      = 1'b1;
        prev_stamp = stamp;
        want_rise  = !want_rise;
      end else begin
        span       = COUNT_WIDTH'(stamp) - COUNT_WIDTH'(prev_stamp);
        prev_stamp = stamp;
        if (want_rise) begin
          want_rise = 1'b0;
          if (span > W1_LO && span < W1_HI) begin
            code = EVT_OFF_LONG;
            hit  = 1'b1;
          end else if (span > W3_LO && span < W3_HI) begin
            code = EVT_OFF_SHORT;
            hit  = 1'b1;
          end
        end else begin
          want_rise = 1'b1;
          if (span > W2_LO && span < W2_HI) begin
            code = EVT_ON_MID;
            hit  = 1'b1;
          end else if (span > W4_LO && span < W4_HI) begin
            code = EVT_ON_SHORT;
            hit  = 1'b1;
          end else if (span > W5_LO && span < W5_HI) begin
            code = EVT_ON_TINY;
            hit  = 1'b1;
          end else if (span > W6_LO && span < W6_HI) begin
            code = EVT_ON_LONG;
            hit  = 1'b1;
          end
        end
      end
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    logic [CODE_WIDTH-1:0] want;
    logic [CODE_WIDTH-1:0] code;
    logic                  hit;
    if (rst) begin
      armed      = 1'b0;
      active     = 1'b0;
      prev_stamp = '0;
      want_rise  = 1'b0;
      expected_codes.delete();
      fail_count     <= 0;
      outstanding    <= 0;
      events_checked <= 0;
      kinds_seen     <= '0;
    end else begin
      if (events.valid && events.ready) begin
        if (expected_codes.size() == 0) begin
          $error("event_code: expected none, actual %0d", events.event_code);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_codes.pop_front();
          events_checked <= events_checked + 1;
          if (events.event_code !== want) begin
            $error("event_code: expected %0d, actual %0d", want, events.event_code);
            fail_count <= fail_count + 1;
          end else begin
            kinds_seen[want] <= 1'b1;
          end
        end
      end
      if (items.valid && items.ready) begin
        hit = predict_event_code(items.func, items.capture_time, code);
        if (hit) expected_codes.push_back(code);
      end
      outstanding <= expected_codes.size();
    end
  end

endmodule

[test/ir_pulse_width_classifier_test.sv]
// Testbench top for the IR pulse width classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module ir_pulse_width_classifier_test;
  import ipwc_pkg::*;

  localparam int RANDOM_ITEMS = 1525;
  localparam int CALM_ITEMS   = 150;
  localparam int HOLD_AT      = 1500;
  localparam int HOLD_CYCLES  = 200;

  typedef enum {SPAN_INSIDE, SPAN_BOUNDARY, SPAN_NOISE} span_mode_t;

  logic clk = 1'b0;
  logic rst;

  ipwc_in_if  in_ch ();
  ipwc_out_if out_ch ();

  int                   fail_count;
  int                   outstanding;
  int                   events_checked;
  logic [EVT_TIMEOUT:0] kinds_seen;

  logic                  calm = 1'b0;
  logic [TIME_WIDTH-1:0] stim_now;
  logic                  stim_rise;
  logic                  stim_armed;
  logic                  stim_active;
  int                    edges_sent;
  int                    ticks_sent;

  always #5 clk = ~clk;

  ir_pulse_width_classifier i_dut (
    .clk    (clk),
    .rst    (rst),
    .items  (in_ch),
    .events (out_ch)
  );

  ipwc_event_check i_check (
    .clk            (clk),
    .rst            (rst),
    .items          (in_ch),
    .events         (out_ch),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .events_checked (events_checked),
    .kinds_seen     (kinds_seen)
  );

  task automatic send_item(input logic kind, input logic [TIME_WIDTH-1:0] stamp);
    in_ch.valid        <= 1'b1;
    in_ch.func         <= kind;
    in_ch.capture_time <= stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic idle_for(input int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_edge(input int span);
    stim_now = stim_now + TIME_WIDTH'(span);
    send_item(FUNC_EDGE, stim_now);
    stim_rise   = !stim_rise;
    stim_armed  = 1'b1;
    stim_active = 1'b1;
    edges_sent++;
  endtask

  task automatic send_tick(input logic [TIME_WIDTH-1:0] junk);
    send_item(FUNC_TICK, junk);
    if (!stim_active) begin
      stim_rise  = 1'b0;
      stim_armed = 1'b0;
    end
    stim_active = 1'b0;
    ticks_sent++;
  endtask

  function automatic void pick_window(input logic rise, output int lo, output int hi);
    if (rise) begin
      if ($urandom_range(0, 1) == 0) begin
        lo = W1_LO;
        hi = W1_HI;
      end else begin
        lo = W3_LO;
        hi = W3_HI;
      end
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          lo = W2_LO;
          hi = W2_HI;
        end
        1: begin
          lo = W4_LO;
          hi = W4_HI;
        end
        2: begin
          lo = W5_LO;
          hi = W5_HI;
        end
        default: begin
          lo = W6_LO;
          hi = W6_HI;
        end
      endcase
    end
  endfunction

  function automatic int pick_span(input logic rise, input span_mode_t mode);
    int lo;
    int hi;
    int span;
    pick_window(rise, lo, hi);
    case (mode)
      SPAN_INSIDE: span = $urandom_range(hi - 1, lo + 1);
      SPAN_BOUNDARY: begin
        case ($urandom_range(0, 3))
          0:       span = lo;
          1:       span = lo + 1;
          2:       span = hi - 1;
          default: span = hi;
        endcase
      end
      default: span = $urandom_range(0, 16'hFFFF);
    endcase
    return span;
  endfunction

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int  cycles;
    int  n;
    logic held;
    out_ch.ready <= 1'b0;
    cycles = 0;
    held   = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && cycles >= HOLD_AT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        n = HOLD_CYCLES;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
        n = 1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 2) != 0);
        n = $urandom_range(1, 16);
      end
      repeat (n) @(posedge clk);
      cycles += n;
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int r;
    int waited;
    span_mode_t mode;
    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_EDGE;
    in_ch.capture_time <= '0;
    stim_now    = 16'hFFFF;
    stim_rise   = 1'b0;
    stim_armed  = 1'b0;
    stim_active = 1'b0;
    edges_sent  = 0;
    ticks_sent  = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: timeouts, every class, strict bounds, timer wrap
    send_tick(16'h0000);
    send_tick(16'hFFFF);
    send_edge(0);
    send_edge(6001);
    send_edge(5001);
    send_edge(801);
    send_edge(2101);
    send_edge(27999);
    send_edge(401);
    send_edge(3999);
    send_edge(24001);
    send_edge(6000);
    send_edge(55999);
    send_edge(800);
    send_edge(2000);
    send_edge(28000);
    send_edge(0);
    send_tick(16'h5A5A);
    send_tick(16'hA5A5);
    send_edge(16'h1234);
    send_edge(65535);
    send_edge(11999);
    send_edge(4000);
    send_edge(56000);
    send_tick(16'h0000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (n == RANDOM_ITEMS / 2 || n == RANDOM_ITEMS / 2 + 1) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      if (!calm && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 16));
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_tick(TIME_WIDTH'($urandom_range(0, 16'hFFFF)));
      end else if (r < 16) begin
        send_tick(TIME_WIDTH'($urandom_range(0, 16'hFFFF)));
        send_tick(TIME_WIDTH'($urandom_range(0, 16'hFFFF)));
        n++;
      end else begin
        r = $urandom_range(0, 99);
        mode = (r < 70) ? SPAN_INSIDE : (r < 82) ? SPAN_BOUNDARY : SPAN_NOISE;
        send_edge(pick_span(stim_rise, mode));
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (outstanding != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);

    $display("covered %0d edges and %0d period ticks, %0d events compared, classes seen %b",
             edges_sent, ticks_sent, events_checked, kinds_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      if (outstanding != 0) $error("event_code: %0d expected events never arrived", outstanding);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
design/ipwc_pkg.sv
design/ipwc_if.sv
design/ipwc_core.sv
design/ir_pulse_width_classifier.sv
test/ipwc_event_check.sv
test/ir_pulse_width_classifier_test.sv
